[hw/rtl/e2q_pkg.sv]
package e2q_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int ANGLE_W           = 16;
    localparam int QUAT_W            = 16;
    localparam int CW                = 33;   // CORDIC x/y width, Q.30 signed
    localparam int ZW                = 34;   // CORDIC residual angle width

    localparam logic signed [ANGLE_W-1:0] PI_Q13  = 16'sd25736;
    localparam logic signed [QUAT_W-1:0]  ONE_Q14 = 16'sd16384;
    localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } angles_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
    } quat_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_lane_t;

    typedef struct packed {
        cordic_lane_t roll;
        cordic_lane_t pitch;
        cordic_lane_t yaw;
    } cordic_set_t;

    // atan(2^-i) in Q.30, truncated.
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] a;
        case (i)
            0:  a = 34'sd843314856;
            1:  a = 34'sd497837829;
            2:  a = 34'sd263043836;
            3:  a = 34'sd133525158;
            4:  a = 34'sd67021686;
            5:  a = 34'sd33543515;
            6:  a = 34'sd16775850;
            7:  a = 34'sd8388437;
            8:  a = 34'sd4194282;
            9:  a = 34'sd2097149;
            10: a = 34'sd1048575;
            11: a = 34'sd524287;
            12: a = 34'sd262143;
            13: a = 34'sd131071;
            14: a = 34'sd65535;
            15: a = 34'sd32767;
            16: a = 34'sd16383;
            17: a = 34'sd8191;
            18: a = 34'sd4095;
            19: a = 34'sd2047;
            20: a = 34'sd1023;
            21: a = 34'sd511;
            22: a = 34'sd255;
            23: a = 34'sd127;
            default: a = '0;
        endcase
        return a;
    endfunction

    // One CORDIC rotation step; both updates use the values from before the step.
    function automatic cordic_lane_t cordic_rot(input cordic_lane_t l, input int i);
        cordic_lane_t r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = l.y >>> i;
        dy = l.x >>> i;
        if (!l.z[ZW-1])
        begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - atan_q30(i);
        end
        else
        begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + atan_q30(i);
        end
        return r;
    endfunction

endpackage

[hw/rtl/euler_to_quaternion_top.sv]
// Channel   Direction  Handshake                   Payload
// angles    in         angle_valid / angle_ready   e2q_pkg::angles_t (roll, pitch, yaw)
// quat      out        quat_valid  / quat_ready    e2q_pkg::quat_t (w, x, y, z)
//
// One beat in, one beat out; a new beat is taken every cycle while quat_ready
// does not stall the pipeline. The stages are one saturation stage, one register per
// CORDIC step, then pair products, triple products and the rounded output.
// rst_n clears only the valid bits; data registers hold no reset value.
// Every stage holds while it is full and its successor cannot take a beat, so a
// stall on quat_ready only backs up as far as the first empty stage.
module euler_to_quaternion_top #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              angle_valid,
    output logic              angle_ready,
    input  e2q_pkg::angles_t  angles,
    output logic              quat_valid,
    input  logic              quat_ready,
    output e2q_pkg::quat_t    quat
);

    localparam int NS = (CORDIC_STAGES < e2q_pkg::ATAN_ENTRIES) ?
                        CORDIC_STAGES : e2q_pkg::ATAN_ENTRIES;

    function automatic e2q_pkg::cordic_lane_t lane_init(
        input logic signed [e2q_pkg::ANGLE_W-1:0] a);
        e2q_pkg::cordic_lane_t l;
        logic signed [e2q_pkg::ANGLE_W-1:0] s;
        if (a > e2q_pkg::PI_Q13)
            s = e2q_pkg::PI_Q13;
        else if (a < -e2q_pkg::PI_Q13)
            s = -e2q_pkg::PI_Q13;
        else
            s = a;
        l.x = e2q_pkg::CORDIC_GAIN_Q30;
        l.y = '0;
        // Halving the Q2.13 angle and moving to Q.30 is one shift by 16.
        l.z = {{(e2q_pkg::ZW-e2q_pkg::ANGLE_W-16){s[e2q_pkg::ANGLE_W-1]}}, s, 16'b0};
        return l;
    endfunction

    logic                 v0_reg;
    e2q_pkg::cordic_set_t d0_reg;
    logic                 r0;

    logic                 cv [0:NS];
    logic                 cr [0:NS];
    e2q_pkg::cordic_set_t cd [0:NS];

    assign r0          = !v0_reg || cr[0];
    assign angle_ready = r0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (r0)
            v0_reg <= angle_valid;
    end

    always_ff @(posedge clk)
    begin
        if (r0 && angle_valid)
        begin
            d0_reg.roll  <= lane_init(angles.roll_angle);
            d0_reg.pitch <= lane_init(angles.pitch_angle);
            d0_reg.yaw   <= lane_init(angles.yaw_angle);
        end
    end

    assign cv[0] = v0_reg;
    assign cd[0] = d0_reg;

    for (genvar i = 0; i < NS; i++)
    begin : g_cordic
        e2q_cordic_stage #(.STAGE(i)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[i]),
            .in_ready  (cr[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_ready (cr[i+1]),
            .out_data  (cd[i+1])
        );
    end

    e2q_quat_math u_math (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv[NS]),
        .in_ready  (cr[NS]),
        .in_data   (cd[NS]),
        .out_valid (quat_valid),
        .out_ready (quat_ready),
        .out_data  (quat)
    );

    // An empty output register must never hold back the input.
    assert property (@(posedge clk) disable iff (!rst_n) !quat_valid |-> angle_ready)
        else $error("input stalled with empty output");

    // Saturation keeps every component within plus or minus one.
    assert property (@(posedge clk) disable iff (!rst_n)
        quat_valid |-> (quat.quat_w <= e2q_pkg::ONE_Q14 && quat.quat_w >= -e2q_pkg::ONE_Q14
                     && quat.quat_x <= e2q_pkg::ONE_Q14 && quat.quat_x >= -e2q_pkg::ONE_Q14
                     && quat.quat_y <= e2q_pkg::ONE_Q14 && quat.quat_y >= -e2q_pkg::ONE_Q14
                     && quat.quat_z <= e2q_pkg::ONE_Q14 && quat.quat_z >= -e2q_pkg::ONE_Q14))
        else $error("quaternion component out of range");

    // A beat taken at the input reaches the input saturation register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (angle_valid && angle_ready) |=> v0_reg)
        else $error("accepted beat lost at input stage");

endmodule

[hw/rtl/e2q_cordic_stage.sv]
module e2q_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  e2q_pkg::cordic_set_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output e2q_pkg::cordic_set_t out_data
);

    logic                 valid_reg;
    e2q_pkg::cordic_set_t data_reg;
    e2q_pkg::cordic_set_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next.roll  = e2q_pkg::cordic_rot(in_data.roll,  STAGE);
        data_next.pitch = e2q_pkg::cordic_rot(in_data.pitch, STAGE);
        data_next.yaw   = e2q_pkg::cordic_rot(in_data.yaw,   STAGE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/e2q_quat_math.sv]
module e2q_quat_math (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  e2q_pkg::cordic_set_t in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output e2q_pkg::quat_t       out_data
);

    localparam int CW = e2q_pkg::CW;
    localparam int AW = 34;              // rounded pair product, Q.30
    localparam int PW = AW + CW;         // triple product, Q.60
    localparam int SW = PW + 1;          // sum of two triples

    function automatic logic signed [AW-1:0] round30(input logic signed [2*CW-1:0] p);
        logic signed [2*CW-1:0] r;
        r = p + (66'sd1 <<< 29);
        return r[AW+29:30];
    endfunction

    function automatic logic signed [e2q_pkg::QUAT_W-1:0] to_q14(
        input logic signed [PW-1:0] a, input logic signed [PW-1:0] b, input logic sub);
        logic signed [SW-1:0] s;
        logic signed [SW-47:0] q;
        logic signed [e2q_pkg::QUAT_W-1:0] o;
        s = sub ? (SW'(a) - SW'(b)) : (SW'(a) + SW'(b));
        s = s + (SW'(1) <<< 45);
        q = s[SW-1:46];
        if (q > (SW-46)'(e2q_pkg::ONE_Q14))
            o = e2q_pkg::ONE_Q14;
        else if (q < -(SW-46)'(e2q_pkg::ONE_Q14))
            o = -e2q_pkg::ONE_Q14;
        else
            o = q[e2q_pkg::QUAT_W-1:0];
        return o;
    endfunction

    // Stage A: yaw x roll pair products, plus pitch passed along.
    logic                 a_valid_reg;
    logic signed [AW-1:0] cc_reg, ss_reg, cs_reg, sc_reg;
    logic signed [CW-1:0] cp_reg, sp_reg;
    // Stage B: the eight triple products.
    logic                 b_valid_reg;
    logic signed [PW-1:0] t_ccc_reg, t_sss_reg, t_csc_reg, t_scs_reg;
    logic signed [PW-1:0] t_ccs_reg, t_ssc_reg, t_scc_reg, t_css_reg;
    // Stage C: output register.
    logic                 c_valid_reg;
    e2q_pkg::quat_t       q_reg;

    logic a_ready, b_ready, c_ready;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
            if (c_ready)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            cc_reg <= round30(in_data.yaw.x * in_data.roll.x);
            ss_reg <= round30(in_data.yaw.y * in_data.roll.y);
            cs_reg <= round30(in_data.yaw.x * in_data.roll.y);
            sc_reg <= round30(in_data.yaw.y * in_data.roll.x);
            cp_reg <= in_data.pitch.x;
            sp_reg <= in_data.pitch.y;
        end
        if (b_ready && a_valid_reg)
        begin
            t_ccc_reg <= cc_reg * cp_reg;
            t_sss_reg <= ss_reg * sp_reg;
            t_csc_reg <= cs_reg * cp_reg;
            t_scs_reg <= sc_reg * sp_reg;
            t_ccs_reg <= cc_reg * sp_reg;
            t_ssc_reg <= ss_reg * cp_reg;
            t_scc_reg <= sc_reg * cp_reg;
            t_css_reg <= cs_reg * sp_reg;
        end
        if (c_ready && b_valid_reg)
        begin
            q_reg.quat_w <= to_q14(t_ccc_reg, t_sss_reg, 1'b0);
            q_reg.quat_x <= to_q14(t_csc_reg, t_scs_reg, 1'b1);
            q_reg.quat_y <= to_q14(t_ccs_reg, t_ssc_reg, 1'b0);
            q_reg.quat_z <= to_q14(t_scc_reg, t_css_reg, 1'b1);
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = q_reg;

endmodule

[tb/sv/e2q_checker.sv]
`timescale 1ns / 1ps

module e2q_checker #(
    parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             angle_valid,
    input  logic             angle_ready,
    input  e2q_pkg::angles_t angles,
    input  logic             quat_valid,
    input  logic             quat_ready,
    input  e2q_pkg::quat_t   quat,
    output int               errors,
    output int               pending
);

    e2q_pkg::quat_t expected_quats[$];

    // Arctangent table in Q.30, truncated.
    localparam longint ATAN_TAB [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127};

    function automatic void half_angle_trig(input logic signed [15:0] raw,
                                            output longint c, output longint s);
        longint a;
        longint cx;
        longint sy;
        longint res;
        longint dx;
        longint dy;
        a = raw;
        if (a > e2q_pkg::PI_Q13) a = e2q_pkg::PI_Q13;
        if (a < -e2q_pkg::PI_Q13) a = -e2q_pkg::PI_Q13;
        cx = e2q_pkg::CORDIC_GAIN_Q30;
        sy = 0;
        res = a * 65536;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++)
        begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (res >= 0)
            begin
                cx -= dx;
                sy += dy;
                res -= ATAN_TAB[i];
            end
            else
            begin
                cx += dx;
                sy -= dy;
                res += ATAN_TAB[i];
            end
        end
        c = cx;
        s = sy;
    endfunction

    function automatic longint triple_q60(input longint a, input longint b, input longint c);
        longint ab;
        ab = (a * b + (longint'(1) << 29)) >>> 30;
        return ab * c;
    endfunction

    function automatic logic signed [15:0] round_q14(input longint v);
        longint r;
        r = (v + (longint'(1) << 45)) >>> 46;
        if (r > e2q_pkg::ONE_Q14) r = e2q_pkg::ONE_Q14;
        if (r < -e2q_pkg::ONE_Q14) r = -e2q_pkg::ONE_Q14;
        return r[15:0];
    endfunction

    function automatic e2q_pkg::quat_t quat_from_euler(input e2q_pkg::angles_t a);
        longint cr, sr, cp, sp, cy, sy;
        e2q_pkg::quat_t q;
        half_angle_trig(a.roll_angle, cr, sr);
        half_angle_trig(a.pitch_angle, cp, sp);
        half_angle_trig(a.yaw_angle, cy, sy);
        q.quat_w = round_q14(triple_q60(cy, cr, cp) + triple_q60(sy, sr, sp));
        q.quat_x = round_q14(triple_q60(cy, sr, cp) - triple_q60(sy, cr, sp));
        q.quat_y = round_q14(triple_q60(cy, cr, sp) + triple_q60(sy, sr, cp));
        q.quat_z = round_q14(triple_q60(sy, cr, cp) - triple_q60(cy, sr, sp));
        return q;
    endfunction

    assign pending = expected_quats.size();

    always @(posedge clk)
    begin
        e2q_pkg::quat_t want;
        if (!rst_n)
            errors = 0;
        else
        begin
            if (angle_valid && angle_ready)
                expected_quats.insert(expected_quats.size(), quat_from_euler(angles));
            if (quat_valid && quat_ready)
            begin
                if (expected_quats.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, quat);
                    errors++;
                end
                else
                begin
                    want = expected_quats.pop_front();
                    if (want.quat_w !== quat.quat_w || want.quat_x !== quat.quat_x ||
                        want.quat_y !== quat.quat_y || want.quat_z !== quat.quat_z)
                    begin
                        $display(
                            "%0t: expected w%0d x%0d y%0d z%0d, actual w%0d x%0d y%0d z%0d",
                            $time, want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                            quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z);
                        errors++;
                    end
                end
            end
        end
    end
endmodule

[tb/sv/tb_euler_to_quaternion_top.sv]
`timescale 1ns / 1ps

module tb_euler_to_quaternion_top;

    localparam int RANDOM_BEATS = 500;
    localparam int LATENCY      = e2q_pkg::CORDIC_STAGES_DEF + 4;
    localparam int CYCLE_LIMIT  = 200000;

    logic             clk;
    logic             rst_n;
    logic             angle_valid;
    logic             angle_ready;
    e2q_pkg::angles_t angles;
    logic             quat_valid;
    logic             quat_ready;
    e2q_pkg::quat_t   quat;
    int               errors;
    int               pending;
    int               cycles;
    bit               calm;

    euler_to_quaternion_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .angle_valid(angle_valid), .angle_ready(angle_ready), .angles(angles),
        .quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat)
    );

    e2q_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .angle_valid(angle_valid), .angle_ready(angle_ready), .angles(angles),
        .quat_valid(quat_valid), .quat_ready(quat_ready), .quat(quat),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Receiver stalls in bursts, none once the calm tail of the run starts.
    initial
    begin
        quat_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                quat_ready <= 0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
            end
            quat_ready <= 1;
        end
    end

    function automatic logic signed [15:0] any_angle();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2 * 25736) - 25736);
            2: return $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
            default: return 16'($urandom_range(0, 2000) - 1000);
        endcase
    endfunction

    task automatic send_angles(input logic signed [15:0] r, input logic signed [15:0] p,
                               input logic signed [15:0] y);
        angle_valid <= 1;
        angles <= '{roll_angle: r, pitch_angle: p, yaw_angle: y};
        do @(posedge clk); while (!angle_ready);
        @(negedge clk);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            angle_valid <= 0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    initial
    begin
        logic signed [15:0] edges [8];
        edges = '{16'sh7FFF, 16'sh8000, 16'sd25736, -16'sd25736, 16'sd25737,
                  -16'sd25737, 16'sd0, 16'sd12868};
        calm = 0;
        rst_n = 0;
        angle_valid = 0;
        angles = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        for (int i = 0; i < 8; i++)
            send_angles(edges[i], edges[7 - i], edges[(i + 3) % 8]);
        send_angles(16'sd0, 16'sd0, 16'sd0);
        send_angles(16'sd25736, 16'sd25736, 16'sd25736);
        send_angles(-16'sd25736, 16'sd12868, -16'sd12868);
        send_angles(16'sd12868, 16'sd12868, 16'sd12868);
        send_angles(16'sh5555, 16'shAAAA, 16'sh7FFF);
        send_angles(16'shAAAA, 16'sh5555, 16'sh8000);

        // Drain completely before the random part.
        angle_valid <= 0;
        while (pending != 0) @(negedge clk);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n == RANDOM_BEATS * 4 / 5)
                calm = 1;
            send_angles(any_angle(), any_angle(), any_angle());
        end
        angle_valid <= 0;

        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 8) @(negedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
